@@ rtl/core/fbfl_pkg.sv @@
package fbfl_pkg;

  // Request kinds carried on in_tuser
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Status from the address checker to the control logic
  typedef struct packed {
    logic done;  // one-cycle pulse: the check of the latched address is complete
    logic hit;   // address is nonzero, inside the pool and block aligned
  } chk_stat_t;

endpackage

@@ rtl/core/fbfl_link_ram.sv @@
module fbfl_link_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_data
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/fbfl_addr_chk.sv @@
module fbfl_addr_chk
  import fbfl_pkg::*;
#(
  parameter int BLOCK_BYTES = 64,
  parameter int BLOCK_COUNT = 64,
  parameter int IDX_W       = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [31:0]      address,
  input  logic [31:0]      base,
  output chk_stat_t        stat,
  output logic [IDX_W-1:0] idx
);

  localparam bit BYTES_POW2 = (BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0;
  localparam logic [32:0] POOL_SIZE = 33'(64'(BLOCK_COUNT) * 64'(BLOCK_BYTES));

  function automatic int trail_zeros(input int value);
    int n;
    n = 0;
    for (int i = 31; i >= 0; i--) begin
      if (value[i]) n = i;
    end
    return n;
  endfunction

  // Newton iteration for the inverse of an odd number modulo 2**32
  function automatic logic [31:0] odd_inverse(input logic [31:0] m);
    logic [31:0] x;
    x = m;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - m * x);
    end
    return x;
  endfunction

  logic [32:0] diff;
  logic [31:0] off;
  logic        range_bad;

  // Borrow out of the subtract means the address lies below the pool
  assign diff      = {1'b0, address} - {1'b0, base};
  assign off       = diff[31:0];
  assign range_bad = (address == 32'd0) || diff[32] || ({1'b0, off} >= POOL_SIZE);

  if (BYTES_POW2) begin : g_shift
    localparam int LOG2_BYTES = $clog2(BLOCK_BYTES);
    localparam logic [31:0] MASK = 32'(BLOCK_BYTES - 1);

    logic             done_r;
    logic             hit_r;
    logic [IDX_W-1:0] idx_r;
    logic [31:0]      quot;

    assign quot = off >> LOG2_BYTES;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else begin
        done_r <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        hit_r <= !range_bad && ((off & MASK) == 32'd0);
        idx_r <= quot[IDX_W-1:0];
      end
    end

    assign stat.done = done_r;
    assign stat.hit  = hit_r;
    assign idx       = idx_r;
  end else begin : g_inv
    // BLOCK_BYTES is 2**TZ times an odd factor. The offset divides evenly when
    // its low TZ bits are zero and the odd part times the inverse of the odd
    // factor, modulo 2**32, stays at or below LIMIT; that product is then the
    // block index. Register the shifted offset, multiply on the next cycle.
    localparam int          TZ       = trail_zeros(BLOCK_BYTES);
    localparam logic [31:0] ODD      = 32'(BLOCK_BYTES >> TZ);
    localparam logic [31:0] INV      = odd_inverse(ODD);
    localparam logic [31:0] LIMIT    = 32'hFFFF_FFFF / ODD;
    localparam logic [31:0] LOW_MASK = 32'((64'd1 << TZ) - 64'd1);

    logic             stage_r;
    logic             done_r;
    logic             bad_r;
    logic [31:0]      odd_part_r;
    logic             hit_r;
    logic [IDX_W-1:0] idx_r;
    logic [31:0]      prod;

    assign prod = odd_part_r * INV;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stage_r <= 1'b0;
        done_r  <= 1'b0;
      end else begin
        stage_r <= start;
        done_r  <= stage_r;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        bad_r      <= range_bad || ((off & LOW_MASK) != 32'd0);
        odd_part_r <= off >> TZ;
      end
      if (stage_r) begin
        hit_r <= !bad_r && (prod <= LIMIT);
        idx_r <= prod[IDX_W-1:0];
      end
    end

    assign stat.done = done_r;
    assign stat.hit  = hit_r;
    assign idx       = idx_r;
  end

endmodule

@@ rtl/core/fixed_block_free_list_allocator_unit.sv @@
// Fixed-size block pool allocator with a first-in first-out free list.
// Input channel in_*: in_tuser is the request kind (0 allocate, 1 free),
// in_tdata the byte address of the block to free (ignored for allocate).
// Output channel out_*: one result per request; out_tuser is ok, out_tdata
// the granted block address (zero when refused and for every free).
// cfg_wr_en/cfg_wr_data write pool_base; write it only while the block is
// idle. Changing it leaves the free list untouched.
// After reset the block sweeps the link memory, one entry per cycle, with
// in_tready low until every entry is written; then all blocks are free in
// order. An allocate from an empty pool loads the output register at its
// accepting edge, a granted allocate in state ST_ALLOC after the link memory
// read. A free loads it once the address check is done, via the checker's
// result register when BLOCK_BYTES is a power of two, else via the
// shifted-offset register and then the result register (reciprocal multiply).
// Granted allocates and frees hold in_tready low until the link memory access
// is done; one request at a time is in work.
// A stalled receiver holds the current result in the output register; the
// next request is still accepted and finished, then waits in a holding
// register, and in_tready stays low until the output register frees up.
module fixed_block_free_list_allocator_unit
  import fbfl_pkg::*;
#(
  parameter int BLOCK_BYTES = 64,
  parameter int BLOCK_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // pool_base
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [31:0] address
  input  logic        in_tuser,      // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [31:0] block_address
  output logic        out_tuser      // [0] ok
);

  localparam int IDX_W = $clog2(BLOCK_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_COUNT - 1);
  localparam logic [31:0] BYTES32 = 32'(BLOCK_BYTES);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ALLOC,
    ST_FREE,
    ST_HOLD
  } state_t;

  state_t           state_r;
  logic [31:0]      pool_base_r;
  logic [IDX_W-1:0] head_r;
  logic [IDX_W-1:0] tail_r;
  logic             empty_r;
  logic [IDX_W-1:0] init_cnt_r;
  logic             out_tvalid_r;
  logic             out_ok_r;
  logic [31:0]      out_addr_r;
  logic             pend_ok_r;
  logic [31:0]      pend_addr_r;

  logic             accept;
  logic             out_free;
  logic             out_load;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_rdata;
  logic             chk_start;
  chk_stat_t        chk_stat;
  logic [IDX_W-1:0] chk_idx;
  logic [31:0]      alloc_addr;
  logic             fin_valid;
  logic             fin_ok;
  logic [31:0]      fin_addr;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign out_load  = out_free && (fin_valid || (state_r == ST_HOLD));

  assign ram_we    = (state_r == ST_INIT) ||
                     ((state_r == ST_FREE) && chk_stat.done && chk_stat.hit && !empty_r);
  assign ram_waddr = (state_r == ST_INIT) ? init_cnt_r : tail_r;
  assign ram_wdata = (state_r == ST_INIT) ?
                     ((init_cnt_r == LAST_IDX) ? '0 : init_cnt_r + IDX_W'(1)) : chk_idx;
  assign ram_re    = accept && (in_tuser == OP_ALLOC) && !empty_r;
  assign chk_start = accept && (in_tuser == OP_FREE);

  assign alloc_addr = pool_base_r + 32'(32'(head_r) * BYTES32);

  fbfl_link_ram #(
    .DEPTH (BLOCK_COUNT),
    .AW    (IDX_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (head_r),
    .rd_data (ram_rdata)
  );

  fbfl_addr_chk #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .BLOCK_COUNT (BLOCK_COUNT),
    .IDX_W       (IDX_W)
  ) u_addr_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (chk_start),
    .address (in_tdata),
    .base    (pool_base_r),
    .stat    (chk_stat),
    .idx     (chk_idx)
  );

  always_comb begin
    fin_valid = 1'b0;
    fin_ok    = 1'b0;
    fin_addr  = '0;
    unique case (state_r)
      ST_IDLE: begin
        // allocate from an empty pool: refuse at once
        fin_valid = accept && (in_tuser == OP_ALLOC) && empty_r;
      end
      ST_ALLOC: begin
        fin_valid = 1'b1;
        fin_ok    = 1'b1;
        fin_addr  = alloc_addr;
      end
      ST_FREE: begin
        fin_valid = chk_stat.done;
        fin_ok    = chk_stat.hit;
      end
      ST_INIT, ST_HOLD: begin
        fin_valid = 1'b0;
      end
      default: begin
        fin_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= 32'h4000_0000;
    end else if (cfg_wr_en) begin
      pool_base_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      init_cnt_r   <= '0;
      head_r       <= '0;
      tail_r       <= LAST_IDX;
      empty_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && !out_load) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_INIT: begin
          init_cnt_r <= init_cnt_r + IDX_W'(1);
          if (init_cnt_r == LAST_IDX) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (in_tuser == OP_FREE) begin
              state_r <= ST_FREE;
            end else if (!empty_r) begin
              state_r <= ST_ALLOC;
            end
          end
        end
        ST_ALLOC: begin
          // last block handed out: mark empty, keep head and tail stale
          if (head_r == tail_r) begin
            empty_r <= 1'b1;
          end else begin
            head_r <= ram_rdata;
          end
        end
        ST_FREE: begin
          if (chk_stat.done && chk_stat.hit) begin
            if (empty_r) begin
              head_r  <= chk_idx;
              empty_r <= 1'b0;
            end
            tail_r <= chk_idx;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_ok_r     <= pend_ok_r;
            out_addr_r   <= pend_addr_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (fin_valid) begin
        if (out_free) begin
          out_tvalid_r <= 1'b1;
          out_ok_r     <= fin_ok;
          out_addr_r   <= fin_addr;
          state_r      <= ST_IDLE;
        end else begin
          pend_ok_r   <= fin_ok;
          pend_addr_r <= fin_addr;
          state_r     <= ST_HOLD;
        end
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = out_addr_r;

  // link memory is never read and written in the same cycle
  assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> !ram_re)
    else $error("link memory read and write overlap");

  // the checker reports only while a free is in work
  assert property (@(posedge clk) disable iff (!rst_n) chk_stat.done |-> (state_r == ST_FREE))
    else $error("address check completed outside a free");

  // the list empties only by handing out the block that was both head and tail
  assert property (@(posedge clk) disable iff (!rst_n)
                   $rose(empty_r) |-> ($past(head_r == tail_r) && $past(state_r == ST_ALLOC)))
    else $error("free list emptied with head and tail apart");

endmodule
